@@ hw/rtl/pwm_duty_command_console_assert.svh @@
// assertion macros used by the console checker
`ifndef PWM_DUTY_COMMAND_CONSOLE_ASSERT_SVH
`define PWM_DUTY_COMMAND_CONSOLE_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define PDC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PDC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/pdc_pkg.sv @@
// shared types and constants of the pwm duty command console
`default_nettype none
package pdc_pkg;

  localparam int LINE_DEPTH_DEF = 128;
  localparam int MAX_RES        = 3;

  localparam logic [15:0] PERIOD_RST  = 16'd3721;
  localparam logic [15:0] TIMEOUT_RST = 16'd500;
  localparam logic [6:0]  DMIN_RST    = 7'd5;
  localparam logic [6:0]  DMAX_RST    = 7'd96;
  localparam logic [15:0] PULSE_RST   = 16'd1116;

  // floor(x/100) = (x*RECIP_100) >> RECIP_SHIFT for x below 2^23
  localparam logic [23:0] RECIP_100   = 24'd10737419;
  localparam int          RECIP_SHIFT = 30;

  localparam logic [31:0] CMD_WORD = "PSYN";

  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CASE_OFS = 8'h20;

  typedef enum logic [3:0] {
    K_ECHO    = 4'd0,
    K_ERASE   = 4'd1,
    K_BELL    = 4'd2,
    K_PROMPT  = 4'd3,
    K_WELCOME = 4'd4,
    K_UNKNOWN = 4'd5,
    K_MISSING = 4'd6,
    K_INVALID = 4'd7,
    K_RANGE   = 4'd8,
    K_OK      = 4'd9,
    K_TOOLONG = 4'd10,
    K_EMPTY   = 4'd15
  } kind_e;

  typedef enum logic [1:0] {
    CFG_PERIOD  = 2'd0,
    CFG_TIMEOUT = 2'd1,
    CFG_DMIN    = 2'd2,
    CFG_DMAX    = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PH_LEAD,
    PH_CMD,
    PH_GAP,
    PH_NUM
  } parse_ph_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HANDLE,
    ST_SCAN,
    ST_MUL,
    ST_DIV,
    ST_FINISH,
    ST_EMIT
  } ctrl_state_e;

  typedef struct packed {
    logic accept;
    logic handle;
    logic scan;
    logic mul;
    logic div;
    logic finish;
    logic out_fire;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_parse;
    logic scan_done;
    logic res_empty;
    logic out_last;
  } dp_status_t;

  typedef struct packed {
    logic [MAX_RES-1:0][3:0] kind;
    logic [MAX_RES-1:0][7:0] chr;
    logic [MAX_RES-1:0][6:0] duty;
    logic [1:0]              cnt;
    logic                    ps;
  } res_buf_t;

endpackage
`default_nettype wire

@@ hw/rtl/pdc_if.sv @@
// input and result channel interfaces of the console
`default_nettype none
interface pdc_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] rx_byte;

  modport source (output valid, output op, output rx_byte, input ready);
  modport sink (input valid, input op, input rx_byte, output ready);
endinterface

interface pdc_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  kind;
  logic [7:0]  out_char;
  logic [6:0]  duty;
  logic [15:0] pulse;
  logic        led;
  logic        last;

  modport source (output valid, output kind, output out_char, output duty,
                  output pulse, output led, output last, input ready);
  modport sink (input valid, input kind, input out_char, input duty,
                input pulse, input led, input last, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/pwm_duty_command_console.sv @@
// top level of the pwm duty command console
// Takes one item per transfer on in_ch_i (a serial byte, or a 10 ms tick when op is 1) and
// returns one to three message codes on out_ch_o, the final one flagged by last; an item
// with nothing to say returns no transfer at all. Items are handled one at a time: the
// block takes no new item until every result of the current one has been transferred.
// A tick or a byte other than Enter is handled and then hands out its results. Enter on a
// stored line of L characters walks the line memory through its single read port, one
// character a cycle, then multiplies, divides by 100 through a reciprocal and clamps, and
// then hands out its results. The line store needs no clearing after reset. Configuration
// (period, timeout, duty limits) is written through cfg_we_i / cfg_idx_i / cfg_data_i while
// the block is idle; the user must keep to this, the block itself does not enforce it.
`default_nettype none
module pwm_duty_command_console #(
  parameter int LINE_DEPTH = pdc_pkg::LINE_DEPTH_DEF
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  pdc_in_if.sink      in_ch_i,
  pdc_out_if.source   out_ch_o,
  input  wire         cfg_we_i,
  input  wire  [1:0]  cfg_idx_i,
  input  wire  [15:0] cfg_data_i
);

  // command and status between the sequencer and the datapath
  pdc_pkg::ctrl_cmd_t  cmd;
  pdc_pkg::dp_status_t status;

  // sequencer: accepts an item, steps the scan and the pulse math, hands out results
  pdc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch_i.valid),
    .in_ready_o  (in_ch_i.ready),
    .out_valid_o (out_ch_o.valid),
    .out_ready_i (out_ch_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // datapath: line store, session and timeout state, parser, pulse width, result buffer
  pdc_dp #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_op_i     (in_ch_i.op),
    .in_byte_i   (in_ch_i.rx_byte),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .out_kind_o  (out_ch_o.kind),
    .out_char_o  (out_ch_o.out_char),
    .out_duty_o  (out_ch_o.duty),
    .out_pulse_o (out_ch_o.pulse),
    .out_led_o   (out_ch_o.led),
    .out_last_o  (out_ch_o.last)
  );

endmodule
`default_nettype wire

@@ hw/rtl/pdc_ctrl.sv @@
// sequencing state machine of the console
`default_nettype none
module pdc_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  input  pdc_pkg::dp_status_t  status_i,
  output pdc_pkg::ctrl_cmd_t   cmd_o
);

  pdc_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pdc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      pdc_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = pdc_pkg::ST_HANDLE;
        end
      end
      pdc_pkg::ST_HANDLE: begin
        cmd_o.handle = 1'b1;
        if (status_i.need_parse) begin
          state_d = pdc_pkg::ST_SCAN;
        end else if (status_i.res_empty) begin
          state_d = pdc_pkg::ST_IDLE;
        end else begin
          state_d = pdc_pkg::ST_EMIT;
        end
      end
      pdc_pkg::ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (status_i.scan_done) begin
          state_d = pdc_pkg::ST_MUL;
        end
      end
      pdc_pkg::ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = pdc_pkg::ST_DIV;
      end
      pdc_pkg::ST_DIV: begin
        cmd_o.div = 1'b1;
        state_d   = pdc_pkg::ST_FINISH;
      end
      pdc_pkg::ST_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d      = status_i.res_empty ? pdc_pkg::ST_IDLE : pdc_pkg::ST_EMIT;
      end
      pdc_pkg::ST_EMIT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          cmd_o.out_fire = 1'b1;
          if (status_i.out_last) begin
            state_d = pdc_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = pdc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ hw/rtl/pdc_dp.sv @@
// console datapath: line store, session state, parser, pulse math, result buffer
`default_nettype none
module pdc_dp #(
  parameter int LINE_DEPTH = pdc_pkg::LINE_DEPTH_DEF
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  pdc_pkg::ctrl_cmd_t  cmd_i,
  output pdc_pkg::dp_status_t status_o,
  input  wire                 in_op_i,
  input  wire  [7:0]          in_byte_i,
  input  wire                 cfg_we_i,
  input  wire  [1:0]          cfg_idx_i,
  input  wire  [15:0]         cfg_data_i,
  output logic [3:0]          out_kind_o,
  output logic [7:0]          out_char_o,
  output logic [6:0]          out_duty_o,
  output logic [15:0]         out_pulse_o,
  output logic                out_led_o,
  output logic                out_last_o
);

  localparam int AW = $clog2(LINE_DEPTH);

  function automatic pdc_pkg::res_buf_t push(pdc_pkg::res_buf_t b, pdc_pkg::kind_e k,
                                             logic [7:0] ch, logic [6:0] d);
    pdc_pkg::res_buf_t r;
    r = b;
    if (b.cnt < 2'(pdc_pkg::MAX_RES)) begin
      r.kind[b.cnt] = k;
      r.chr[b.cnt]  = ch;
      r.duty[b.cnt] = d;
      r.cnt         = b.cnt + 2'd1;
    end
    r.ps = (k == pdc_pkg::K_PROMPT) || (k == pdc_pkg::K_BELL);
    return r;
  endfunction

  function automatic pdc_pkg::res_buf_t prompt_once(pdc_pkg::res_buf_t b);
    pdc_pkg::res_buf_t r;
    r = b;
    if (!b.ps) begin
      r = push(b, pdc_pkg::K_PROMPT, 8'd0, 7'd0);
    end
    return r;
  endfunction

  function automatic logic is_sep(logic [7:0] c);
    return (c == pdc_pkg::CH_SPACE) || (c == pdc_pkg::CH_TAB);
  endfunction

  function automatic logic is_dig(logic [7:0] c);
    return (c >= pdc_pkg::CH_ZERO) && (c <= pdc_pkg::CH_NINE);
  endfunction

  // configuration
  logic [15:0] period_q, timeout_q;
  logic [6:0]  dmin_q, dmax_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q  <= pdc_pkg::PERIOD_RST;
      timeout_q <= pdc_pkg::TIMEOUT_RST;
      dmin_q    <= pdc_pkg::DMIN_RST;
      dmax_q    <= pdc_pkg::DMAX_RST;
    end else if (cfg_we_i) begin
      unique case (pdc_pkg::cfg_idx_e'(cfg_idx_i))
        pdc_pkg::CFG_PERIOD:  period_q  <= cfg_data_i;
        pdc_pkg::CFG_TIMEOUT: timeout_q <= cfg_data_i;
        pdc_pkg::CFG_DMIN:    dmin_q    <= cfg_data_i[6:0];
        pdc_pkg::CFG_DMAX:    dmax_q    <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // captured item
  logic       op_q;
  logic [7:0] byte_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q   <= in_op_i;
      byte_q <= in_byte_i;
    end
  end

  // session state
  logic [AW-1:0] len_q, len_d;
  logic          ps_q, ps_d;
  logic          active_q, active_d;
  logic          owed_q, owed_d;
  logic          seen_q, seen_d;
  logic          led_q, led_d;
  logic [31:0]   tick_q, tick_d;
  logic [31:0]   lastrx_q, lastrx_d;
  logic [15:0]   pulse_q, pulse_d;

  pdc_pkg::res_buf_t buf_q, buf_d, b;
  logic [1:0]        oidx_q, oidx_d;

  // line memory
  logic [7:0]    mem [LINE_DEPTH];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic [AW-1:0] scan_q, scan_d;
  logic [7:0]    rd_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem[scan_d];
  end

  // parser state
  pdc_pkg::parse_ph_e ph_q, ph_d;
  logic [2:0]  clen_q, clen_d;
  logic        cmatch_q, cmatch_d;
  logic        neg_q, neg_d;
  logic        hasdig_q, hasdig_d;
  logic [9:0]  mag_q, mag_d;
  logic [13:0] mag_acc;
  logic        term;
  pdc_pkg::kind_e term_kind, end_kind, eval_kind, rkind_q, rkind_d;
  logic [6:0]  rduty_q, rduty_d;
  logic        need_parse;
  logic [7:0]  uc;
  logic [7:0]  cmd_ch;

  // pulse math
  logic [15:0] per_eff;
  logic [22:0] prod_q;
  logic [46:0] recip_prod;
  logic [16:0] quo_q;
  logic [15:0] clamp_v;

  assign per_eff = (period_q == 16'd0) ? 16'd1 : period_q;
  assign recip_prod = 47'(prod_q) * 47'(pdc_pkg::RECIP_100);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_q <= 23'(per_eff) * 23'(rduty_q);
    end
    if (cmd_i.div) begin
      quo_q <= recip_prod[pdc_pkg::RECIP_SHIFT +: 17];
    end
  end

  always_comb begin
    if (quo_q >= {1'b0, per_eff}) begin
      clamp_v = per_eff - 16'd1;
    end else begin
      clamp_v = quo_q[15:0];
    end
    if (clamp_v == 16'd0) begin
      clamp_v = 16'd1;
    end
  end

  // parser step on one stored character
  always_comb begin
    ph_d      = ph_q;
    clen_d    = clen_q;
    cmatch_d  = cmatch_q;
    neg_d     = neg_q;
    hasdig_d  = hasdig_q;
    mag_d     = mag_q;
    term      = 1'b0;
    term_kind = pdc_pkg::K_INVALID;
    mag_acc   = 14'(mag_q) * 14'd10 + 14'(rd_q - pdc_pkg::CH_ZERO);
    cmd_ch    = pdc_pkg::CMD_WORD[8*(3-clen_q[1:0]) +: 8];
    eval_kind = pdc_pkg::K_OK;
    end_kind  = pdc_pkg::K_EMPTY;
    case (ph_q)
      pdc_pkg::PH_LEAD: begin
        if (!is_sep(rd_q)) begin
          ph_d     = pdc_pkg::PH_CMD;
          clen_d   = 3'd1;
          cmatch_d = (rd_q == pdc_pkg::CMD_WORD[31:24]);
        end
      end
      pdc_pkg::PH_CMD: begin
        if (is_sep(rd_q)) begin
          if (clen_q == 3'd4 && cmatch_q) begin
            ph_d = pdc_pkg::PH_GAP;
          end else begin
            term      = 1'b1;
            term_kind = pdc_pkg::K_UNKNOWN;
          end
        end else begin
          cmatch_d = cmatch_q && (clen_q < 3'd4) && (rd_q == cmd_ch);
          clen_d   = (clen_q < 3'd5) ? clen_q + 3'd1 : clen_q;
        end
      end
      pdc_pkg::PH_GAP: begin
        if (rd_q == pdc_pkg::CH_PLUS || rd_q == pdc_pkg::CH_MINUS) begin
          ph_d  = pdc_pkg::PH_NUM;
          neg_d = (rd_q == pdc_pkg::CH_MINUS);
        end else if (is_dig(rd_q)) begin
          ph_d     = pdc_pkg::PH_NUM;
          mag_d    = 10'(rd_q - pdc_pkg::CH_ZERO);
          hasdig_d = 1'b1;
        end else if (!is_sep(rd_q)) begin
          term = 1'b1;
        end
      end
      pdc_pkg::PH_NUM: begin
        if (is_dig(rd_q)) begin
          mag_d    = (mag_acc > 14'd1000) ? 10'd1000 : mag_acc[9:0];
          hasdig_d = 1'b1;
        end else begin
          term = 1'b1;
        end
      end
      default: ;
    endcase
    // range check on the number as it stands after this character
    if ((neg_d && mag_d != 10'd0) || mag_d < 10'(dmin_q) || mag_d > 10'(dmax_q)) begin
      eval_kind = pdc_pkg::K_RANGE;
    end
    if (term && ph_q == pdc_pkg::PH_NUM && is_sep(rd_q) && hasdig_q) begin
      term_kind = eval_kind;
    end
    case (ph_d)
      pdc_pkg::PH_LEAD: end_kind = pdc_pkg::K_EMPTY;
      pdc_pkg::PH_CMD: begin
        end_kind = (clen_d == 3'd4 && cmatch_d) ? pdc_pkg::K_MISSING : pdc_pkg::K_UNKNOWN;
      end
      pdc_pkg::PH_GAP: end_kind = pdc_pkg::K_MISSING;
      pdc_pkg::PH_NUM: end_kind = hasdig_d ? eval_kind : pdc_pkg::K_INVALID;
      default: end_kind = pdc_pkg::K_EMPTY;
    endcase
  end

  // item handling and result collection
  always_comb begin
    len_d     = len_q;
    ps_d      = ps_q;
    active_d  = active_q;
    owed_d    = owed_q;
    seen_d    = seen_q;
    led_d     = led_q;
    tick_d    = tick_q;
    lastrx_d  = lastrx_q;
    pulse_d   = pulse_q;
    buf_d     = buf_q;
    oidx_d    = oidx_q;
    scan_d    = scan_q;
    rkind_d   = rkind_q;
    rduty_d   = rduty_q;
    mem_we    = 1'b0;
    mem_waddr = len_q;
    need_parse = 1'b0;
    b         = buf_q;
    b.ps      = ps_q;
    uc        = ((byte_q >= pdc_pkg::CH_LA) && (byte_q <= pdc_pkg::CH_LZ)) ?
                byte_q - pdc_pkg::CASE_OFS : byte_q;
    mem_wdata = uc;

    if (cmd_i.handle) begin
      b.cnt  = 2'd0;
      scan_d = '0;
      if (owed_q) begin
        owed_d = 1'b0;
        b = push(b, pdc_pkg::K_WELCOME, 8'd0, 7'd0);
        b = push(b, pdc_pkg::K_PROMPT, 8'd0, 7'd0);
      end
      if (!op_q) begin
        lastrx_d = tick_q;
        seen_d   = 1'b1;
        led_d    = !led_q;
        if (!active_q) begin
          active_d = 1'b1;
          len_d    = '0;
          b = push(b, pdc_pkg::K_WELCOME, 8'd0, 7'd0);
          b = push(b, pdc_pkg::K_PROMPT, 8'd0, 7'd0);
        end
        if (byte_q == pdc_pkg::CH_BS || byte_q == pdc_pkg::CH_DEL) begin
          if (len_d != '0) begin
            len_d = len_d - 1'b1;
            b = push(b, pdc_pkg::K_ERASE, 8'd0, 7'd0);
          end else begin
            b = push(b, pdc_pkg::K_BELL, 8'd0, 7'd0);
          end
        end else if (byte_q == pdc_pkg::CH_CR || byte_q == pdc_pkg::CH_LF) begin
          if (len_d != '0) begin
            need_parse = 1'b1;
          end else begin
            b = prompt_once(b);
          end
        end else if (byte_q >= pdc_pkg::CH_SPACE) begin
          b = push(b, pdc_pkg::K_ECHO, uc, 7'd0);
          if ((AW+1)'(len_d) + 1'b1 < (AW+1)'(LINE_DEPTH)) begin
            mem_we    = 1'b1;
            mem_waddr = len_d;
            len_d     = len_d + 1'b1;
          end else begin
            b = push(b, pdc_pkg::K_TOOLONG, 8'd0, 7'd0);
            b = prompt_once(b);
            len_d = '0;
          end
        end
      end else begin
        if (active_q && seen_q && (tick_q - lastrx_q) >= {16'd0, timeout_q}) begin
          active_d = 1'b0;
        end
        tick_d = tick_q + 32'd1;
      end
      buf_d  = b;
      ps_d   = b.ps;
      oidx_d = 2'd0;
    end

    if (cmd_i.scan) begin
      scan_d = scan_q + 1'b1;
      if (status_o.scan_done) begin
        rkind_d = term ? term_kind : end_kind;
        rduty_d = mag_d[6:0];
      end
    end

    if (cmd_i.finish) begin
      if (rkind_q == pdc_pkg::K_EMPTY) begin
        b = prompt_once(b);
      end else if (rkind_q == pdc_pkg::K_OK) begin
        pulse_d = clamp_v;
        b = push(b, pdc_pkg::K_OK, 8'd0, rduty_q);
      end else begin
        b = push(b, rkind_q, 8'd0, 7'd0);
      end
      len_d = '0;
      buf_d = b;
      ps_d  = b.ps;
    end

    if (cmd_i.out_fire) begin
      oidx_d = oidx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q    <= '0;
      ps_q     <= 1'b0;
      active_q <= 1'b1;
      owed_q   <= 1'b1;
      seen_q   <= 1'b0;
      led_q    <= 1'b0;
      tick_q   <= '0;
      lastrx_q <= '0;
      pulse_q  <= pdc_pkg::PULSE_RST;
      buf_q    <= '0;
      oidx_q   <= '0;
    end else begin
      len_q    <= len_d;
      ps_q     <= ps_d;
      active_q <= active_d;
      owed_q   <= owed_d;
      seen_q   <= seen_d;
      led_q    <= led_d;
      tick_q   <= tick_d;
      lastrx_q <= lastrx_d;
      pulse_q  <= pulse_d;
      buf_q    <= buf_d;
      oidx_q   <= oidx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_q  <= scan_d;
    rkind_q <= rkind_d;
    rduty_q <= rduty_d;
    if (cmd_i.handle) begin
      ph_q     <= pdc_pkg::PH_LEAD;
      clen_q   <= '0;
      cmatch_q <= 1'b0;
      neg_q    <= 1'b0;
      hasdig_q <= 1'b0;
      mag_q    <= '0;
    end else if (cmd_i.scan) begin
      ph_q     <= ph_d;
      clen_q   <= clen_d;
      cmatch_q <= cmatch_d;
      neg_q    <= neg_d;
      hasdig_q <= hasdig_d;
      mag_q    <= mag_d;
    end
  end

  assign status_o.need_parse = need_parse;
  assign status_o.scan_done  = term || (scan_q == len_q - 1'b1);
  assign status_o.res_empty  = (buf_d.cnt == 2'd0);
  assign status_o.out_last   = (oidx_q == buf_q.cnt - 2'd1);

  assign out_kind_o  = buf_q.kind[oidx_q];
  assign out_char_o  = buf_q.chr[oidx_q];
  assign out_duty_o  = buf_q.duty[oidx_q];
  assign out_pulse_o = pulse_q;
  assign out_led_o   = led_q;
  assign out_last_o  = status_o.out_last;

endmodule
`default_nettype wire

@@ hw/rtl/pdc_checker.sv @@
// port-level checks of the console and their bind
`default_nettype none
`include "pwm_duty_command_console_assert.svh"
module pdc_checker (
  input wire       clk_i,
  input wire       rst_ni,
  input wire       in_ready_i,
  input wire       out_valid_i,
  input wire       out_ready_i,
  input wire [3:0] out_kind_i,
  input wire [7:0] out_char_i,
  input wire [6:0] out_duty_i,
  input wire       out_last_i
);

  // results and new items never overlap
  `PDC_ASSERT_IMP(a_no_accept_while_emit, out_valid_i, !in_ready_i, "item taken while emitting")
  // a result transferred without last is followed by another result
  `PDC_ASSERT_NXT(a_more_after_notlast, out_valid_i && out_ready_i && !out_last_i, out_valid_i, "results ended without last")
  // only echo carries a character
  `PDC_ASSERT_IMP(a_char_only_echo, out_valid_i && out_kind_i != pdc_pkg::K_ECHO, out_char_i == 8'd0, "character on a non-echo result")
  // only ok carries a duty
  `PDC_ASSERT_IMP(a_duty_only_ok, out_valid_i && out_kind_i != pdc_pkg::K_OK, out_duty_i == 7'd0, "duty on a non-ok result")

endmodule

bind pwm_duty_command_console pdc_checker u_pdc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_ch_i.ready),
  .out_valid_i (out_ch_o.valid),
  .out_ready_i (out_ch_o.ready),
  .out_kind_i  (out_ch_o.kind),
  .out_char_i  (out_ch_o.out_char),
  .out_duty_i  (out_ch_o.duty),
  .out_last_i  (out_ch_o.last)
);
`default_nettype wire
